// ===== rtl/core/hpa_pkg.sv =====
// Package for the pooled handle allocator: sizes, status codes, shared types.
// No dependencies; used by every module under rtl/core.
`default_nettype none

package hpa_pkg;

  localparam int SLOTS_PER_POOL = 1024;
  localparam int MAX_POOLS      = 8;

  localparam int SLOT_W      = $clog2(SLOTS_PER_POOL);
  localparam int POOL_W      = $clog2(MAX_POOLS);
  localparam int POOL_CNT_W  = $clog2(MAX_POOLS + 1);
  localparam int HANDLE_W    = 13;
  localparam int LINK_AW     = POOL_W + SLOT_W;
  localparam int LINK_DEPTH  = MAX_POOLS * SLOTS_PER_POOL;
  localparam int FREED_W     = $clog2(2 * SLOTS_PER_POOL);
  localparam int FREED_CAP   = 2 * SLOTS_PER_POOL - 1;
  localparam int UNISSUED_W  = $clog2(SLOTS_PER_POOL + 1);
  localparam int LIVE_W      = 14;
  localparam int LIVE_CAP    = (1 << LIVE_W) - 1;
  localparam int STATUS_W    = 2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_OWNED = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // request from the control FSM to the pool table
  typedef struct packed {
    logic              take;
    logic              is_free;
    logic [POOL_W-1:0] hpool;
    logic [SLOT_W-1:0] hslot;
  } pool_cmd_t;

  // late head update once the link memory read returns
  typedef struct packed {
    logic              en;
    logic [POOL_W-1:0] pool;
    logic [SLOT_W-1:0] head;
  } pool_pop_t;

  // decision and lookup seen by the control FSM
  typedef struct packed {
    logic              found;
    logic              owned;
    logic              from_list;
    logic [POOL_W-1:0] pool;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] head;
  } pool_view_t;

endpackage

`default_nettype wire

// ===== rtl/core/hpa_link_ram.sv =====
// Free-list link memory: one write port, one read port, registered read data.
// Depends on hpa_pkg.
`default_nettype none

module hpa_link_ram (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [hpa_pkg::LINK_AW-1:0] waddr,
  input  wire logic [hpa_pkg::SLOT_W-1:0]  wdata,
  input  wire logic                       re,
  input  wire logic [hpa_pkg::LINK_AW-1:0] raddr,
  output logic      [hpa_pkg::SLOT_W-1:0]  rdata
);

  logic [hpa_pkg::SLOT_W-1:0] mem [hpa_pkg::LINK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hpa_pool_table.sv =====
// Per-pool counters and free-list heads, pool pick by priority encoding.
// Depends on hpa_pkg.
`default_nettype none

module hpa_pool_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpa_pkg::pool_cmd_t  cmd,
  input  wire hpa_pkg::pool_pop_t  pop,
  output hpa_pkg::pool_view_t      view
);

  logic [hpa_pkg::FREED_W-1:0]    freed_r    [hpa_pkg::MAX_POOLS];
  logic [hpa_pkg::UNISSUED_W-1:0] unissued_r [hpa_pkg::MAX_POOLS];
  logic [hpa_pkg::SLOT_W-1:0]     head_r     [hpa_pkg::MAX_POOLS];
  logic [hpa_pkg::POOL_CNT_W-1:0] open_r, open_nxt;

  logic [hpa_pkg::MAX_POOLS-1:0]  avail;
  logic                           found_open;
  logic                           can_open;
  logic [hpa_pkg::POOL_W-1:0]     first_pool;
  logic [hpa_pkg::POOL_W-1:0]     alloc_pool;
  logic [hpa_pkg::POOL_W-1:0]     lk;
  logic [hpa_pkg::UNISSUED_W-1:0] unissued_m1;
  logic                           do_alloc;
  logic                           do_free;

  always_comb begin
    for (int p = 0; p < hpa_pkg::MAX_POOLS; p++) begin
      avail[p] = (hpa_pkg::POOL_CNT_W'(p) < open_r) &&
                 ((freed_r[p] != '0) || (unissued_r[p] != '0));
    end
    found_open = 1'b0;
    first_pool = '0;
    for (int p = hpa_pkg::MAX_POOLS - 1; p >= 0; p--) begin
      if (avail[p]) begin
        found_open = 1'b1;
        first_pool = hpa_pkg::POOL_W'(p);
      end
    end
  end

  assign can_open    = open_r < hpa_pkg::POOL_CNT_W'(hpa_pkg::MAX_POOLS);
  // a new pool still holds its reset counters
  assign alloc_pool  = found_open ? first_pool : hpa_pkg::POOL_W'(open_r);
  assign lk          = cmd.is_free ? cmd.hpool : alloc_pool;
  assign unissued_m1 = unissued_r[lk] - 1'b1;

  always_comb begin
    view.found     = found_open | can_open;
    view.owned     = hpa_pkg::POOL_CNT_W'(cmd.hpool) < open_r;
    view.from_list = freed_r[lk] != '0;
    view.pool      = alloc_pool;
    view.head      = head_r[lk];
    view.slot      = view.from_list ? head_r[lk] : unissued_m1[hpa_pkg::SLOT_W-1:0];
  end

  assign do_alloc = cmd.take && !cmd.is_free && view.found;
  assign do_free  = cmd.take && cmd.is_free && view.owned;

  always_comb begin
    open_nxt = open_r;
    if (do_alloc && !found_open) begin
      open_nxt = open_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      for (int p = 0; p < hpa_pkg::MAX_POOLS; p++) begin
        freed_r[p]    <= '0;
        unissued_r[p] <= hpa_pkg::UNISSUED_W'(hpa_pkg::SLOTS_PER_POOL);
        head_r[p]     <= '0;
      end
    end else begin
      open_r <= open_nxt;
      if (do_alloc) begin
        if (view.from_list) begin
          freed_r[lk] <= freed_r[lk] - 1'b1;
        end else begin
          unissued_r[lk] <= unissued_m1;
        end
      end
      if (do_free) begin
        head_r[lk] <= cmd.hslot;
        if (freed_r[lk] != hpa_pkg::FREED_W'(hpa_pkg::FREED_CAP)) begin
          freed_r[lk] <= freed_r[lk] + 1'b1;
        end
      end
      if (pop.en) begin
        head_r[pop.pool] <= pop.head;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/pooled_handle_allocator_unit.sv =====
// Top level of the pooled handle allocator: control FSM, live count, result register.
// Depends on hpa_pkg, hpa_pool_table and hpa_link_ram.
//
//  channel | dir | tdata                                   | tuser
//  in_     | in  | [12:0] handle, [15:13] zero              | [0] action (0 alloc, 1 free)
//  out_    | out | [12:0] granted_handle, [26:13] live_handles, [31:27] zero | [1:0] status
//
// A free, an allocation from a never-issued slot and any rejected request are
// done in the idle state; an allocation that reuses a freed slot then passes through
// the pop state, where the registered link memory read yields the new free-list head.
// Reset: synchronous, active low; counters and heads clear at once, the link
// memory is not cleared (a link is only read after it has been written).
// Stalls: the result sits in an output register; a new transaction is taken only in
// the idle state, while that register is empty or its result is taken in the same cycle.
`default_nettype none

module pooled_handle_allocator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [12:0] handle
  input  wire logic [0:0]  in_tuser,   // [0] action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata,  // [12:0] granted_handle, [26:13] live_handles
  output logic      [1:0]  out_tuser   // [1:0] status
);

  hpa_pkg::state_t st_r, st_nxt;

  hpa_pkg::pool_cmd_t  cmd;
  hpa_pkg::pool_pop_t  pop;
  hpa_pkg::pool_view_t view;

  logic                              accept;
  logic [hpa_pkg::HANDLE_W-1:0]      handle;
  logic                              link_we;
  logic                              link_re;
  logic [hpa_pkg::SLOT_W-1:0]        link_rdata;

  logic [hpa_pkg::POOL_W-1:0]        pop_pool_r, pop_pool_nxt;
  logic [hpa_pkg::LIVE_W-1:0]        live_r, live_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [hpa_pkg::HANDLE_W-1:0]      granted_r, granted_nxt;
  logic [hpa_pkg::STATUS_W-1:0]      status_r, status_nxt;
  logic [hpa_pkg::LIVE_W-1:0]        live_out_r;

  assign handle    = in_tdata[hpa_pkg::HANDLE_W-1:0];
  assign in_tready = (st_r == hpa_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.take    = accept;
    cmd.is_free = in_tuser[0];
    cmd.hpool   = handle[hpa_pkg::HANDLE_W-1 -: hpa_pkg::POOL_W];
    cmd.hslot   = handle[hpa_pkg::SLOT_W-1:0];
  end

  hpa_pool_table u_pool_table (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .pop   (pop),
    .view  (view)
  );

  // push writes the old head into the freed slot; pop reads the head's link
  assign link_we = accept && cmd.is_free && view.owned;
  assign link_re = accept && !cmd.is_free && view.found && view.from_list;

  hpa_link_ram u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr ({cmd.hpool, cmd.hslot}),
    .wdata (view.head),
    .re    (link_re),
    .raddr ({view.pool, view.head}),
    .rdata (link_rdata)
  );

  always_comb begin
    pop.en   = st_r == hpa_pkg::ST_POP;
    pop.pool = pop_pool_r;
    pop.head = link_rdata;
  end

  always_comb begin
    st_nxt        = st_r;
    pop_pool_nxt  = pop_pool_r;
    live_nxt      = live_r;
    out_valid_nxt = out_valid_r && !out_tready;
    granted_nxt   = granted_r;
    status_nxt    = status_r;
    case (st_r)
      hpa_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          granted_nxt   = '0;
          status_nxt    = hpa_pkg::STATUS_OK;
          if (!cmd.is_free) begin
            if (view.found) begin
              granted_nxt = {view.pool, view.slot};
              if (live_r != hpa_pkg::LIVE_W'(hpa_pkg::LIVE_CAP)) begin
                live_nxt = live_r + 1'b1;
              end
              if (view.from_list) begin
                st_nxt       = hpa_pkg::ST_POP;
                pop_pool_nxt = view.pool;
              end
            end else begin
              status_nxt = hpa_pkg::STATUS_NO_SPACE;
            end
          end else if (view.owned) begin
            if (live_r != '0) begin
              live_nxt = live_r - 1'b1;
            end
          end else begin
            status_nxt = hpa_pkg::STATUS_NOT_OWNED;
          end
        end
      end
      hpa_pkg::ST_POP: begin
        st_nxt = hpa_pkg::ST_IDLE;
      end
      default: begin
        st_nxt = hpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= hpa_pkg::ST_IDLE;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_pool_r <= pop_pool_nxt;
    granted_r  <= granted_nxt;
    status_r   <= status_nxt;
    if (accept) begin
      live_out_r <= live_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, live_out_r, granted_r};
  assign out_tuser  = status_r;

  // the pop state always returns to idle on the next clock
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == hpa_pkg::ST_POP |=> st_r == hpa_pkg::ST_IDLE)
    else $error("pop state held beyond one cycle");

  // the link memory is never read and written in the same cycle
  a_link_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(link_re && link_we))
    else $error("link memory read and write collide");

  // a failed request never carries a handle
  a_fail_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != hpa_pkg::STATUS_OK) |-> granted_r == '0)
    else $error("handle reported on failed request");

  // live count moves only when a request is taken
  a_live_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(live_r))
    else $error("live count changed without a transaction");

endmodule

`default_nettype wire

// ===== test/tb_pooled_handle_allocator_unit.sv =====
// Self-checking testbench for pooled_handle_allocator_unit: stream stimulus, own allocator
// predictor, result scoreboard. Depends on hpa_pkg and the RTL under rtl/core only.
module tb_pooled_handle_allocator_unit;
  import hpa_pkg::*;

  localparam int      CLK_PERIOD   = 10;
  localparam int      RANDOM_ITEMS = 1590;
  localparam int      HOLD_CYCLES  = 300;
  localparam int      SETTLE       = 8;       // settling margin after the drain, covering the pop wait
  localparam int      DRAIN_LIMIT  = 20000;
  localparam longint  RUN_LIMIT    = 64'd2_000_000;

  // request kinds carried on in_tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] granted;
    logic [STATUS_W-1:0] status;
    logic [LIVE_W-1:0]   live;
  } alloc_resp_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;          // [12:0] handle, [15:13] zero
  logic [0:0]  in_tuser;          // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [12:0] granted_handle, [26:13] live_handles
  logic [1:0]  out_tuser;         // [1:0] status

  pooled_handle_allocator_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the allocator state, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [SLOT_W-1:0]     link_shadow   [LINK_DEPTH];
  logic [FREED_W-1:0]    freed_len     [MAX_POOLS];
  logic [UNISSUED_W-1:0] unissued_left [MAX_POOLS];
  logic [SLOT_W-1:0]     list_head     [MAX_POOLS];
  logic [POOL_CNT_W-1:0] pools_opened;
  logic [LIVE_W-1:0]     live_tally;

  alloc_resp_t awaited_responses[$];   // predictions not yet matched by the DUT
  alloc_resp_t last_resp;              // prediction for the latest accepted request
  logic [HANDLE_W-1:0] held_handles[$];

  int  tx_idle_pct;
  int  rx_stall_pct;
  bit  rx_hold;
  int  fail_count;
  int  n_checked;
  int  n_granted;
  int  n_no_space;
  int  n_unowned;
  int  peak_live;

  function automatic void reset_shadow();
    foreach (link_shadow[i]) link_shadow[i] = '0;
    for (int p = 0; p < MAX_POOLS; p++) begin
      freed_len[p]     = '0;
      unissued_left[p] = UNISSUED_W'(SLOTS_PER_POOL);
      list_head[p]     = '0;
    end
    pools_opened = '0;
    live_tally   = '0;
  endfunction

  // Works out the response to one request and moves the shadow state on.
  function automatic alloc_resp_t predict_response(input logic act,
                                                   input logic [HANDLE_W-1:0] hdl);
    alloc_resp_t       r;
    int                sel;
    bit                found;
    logic [SLOT_W-1:0] slot;
    r     = '{granted: '0, status: STATUS_OK, live: '0};
    found = 1'b0;
    sel   = 0;
    if (act == ACT_ALLOC) begin
      // lowest open pool with anything left wins
      for (int i = int'(pools_opened) - 1; i >= 0; i--) begin
        if (freed_len[i] != 0 || unissued_left[i] != 0) begin
          found = 1'b1;
          sel   = i;
        end
      end
      // everything open is exhausted: open the next pool lazily
      if (!found && pools_opened < MAX_POOLS) begin
        sel                = pools_opened;
        pools_opened       = pools_opened + 1'b1;
        freed_len[sel]     = '0;
        unissued_left[sel] = UNISSUED_W'(SLOTS_PER_POOL);
        list_head[sel]     = '0;
        found              = 1'b1;
      end
      if (found) begin
        if (freed_len[sel] != 0) begin
          // LIFO reuse: pop the head, follow its link
          slot           = list_head[sel];
          list_head[sel] = link_shadow[sel * SLOTS_PER_POOL + slot];
          freed_len[sel] = freed_len[sel] - 1'b1;
        end else begin
          // never-issued slots go from the top down
          unissued_left[sel] = unissued_left[sel] - 1'b1;
          slot               = unissued_left[sel][SLOT_W-1:0];
        end
        r.granted = HANDLE_W'(sel * SLOTS_PER_POOL + slot);
        if (live_tally < LIVE_CAP) live_tally = live_tally + 1'b1;
      end else begin
        r.status = STATUS_NO_SPACE;
      end
    end else begin
      sel  = hdl / SLOTS_PER_POOL;
      slot = SLOT_W'(hdl % SLOTS_PER_POOL);
      if (sel < pools_opened) begin
        // push; double frees are not caught, the count just saturates
        link_shadow[sel * SLOTS_PER_POOL + slot] = list_head[sel];
        list_head[sel]                           = slot;
        if (freed_len[sel] < FREED_CAP) freed_len[sel] = freed_len[sel] + 1'b1;
        if (live_tally > 0) live_tally = live_tally - 1'b1;
      end else begin
        r.status = STATUS_NOT_OWNED;
      end
    end
    r.live = live_tally;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one transaction per call, inputs move on the falling edge
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic act, input logic [HANDLE_W-1:0] hdl);
    // random gap first; valid stays high between back-to-back requests
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, hdl};
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_resp = predict_response(act, hdl);
    awaited_responses.push_back(last_resp);
    case (last_resp.status)
      STATUS_OK:        if (act == ACT_ALLOC) n_granted++;
      STATUS_NO_SPACE:  n_no_space++;
      STATUS_NOT_OWNED: n_unowned++;
      default: ;
    endcase
    if (int'(last_resp.live) > peak_live) peak_live = last_resp.live;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready changes on the falling edge, a forced hold-off wins
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
  end

  // rx_hold moves on the rising edge so the falling-edge driver never races it
  task automatic hold_receiver(input int cycles);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  // Scoreboard: every accepted result against the oldest prediction
  always @(posedge clk) begin
    alloc_resp_t want;
    alloc_resp_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.granted = out_tdata[HANDLE_W-1:0];
      got.live    = out_tdata[HANDLE_W +: LIVE_W];
      got.status  = out_tuser;
      n_checked++;
      if (awaited_responses.size() == 0) begin
        $error("unexpected result transaction: granted_handle %0d status %0d live %0d",
               got.granted, got.status, got.live);
        fail_count++;
      end else begin
        want = awaited_responses.pop_front();
        if (got.granted !== want.granted) begin
          $error("granted_handle: expected %0d, got %0d", want.granted, got.granted);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.live !== want.live) begin
          $error("live_handles: expected %0d, got %0d", want.live, got.live);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners: first pool opening, top-down issue, LIFO reuse, frees into
  // unopened pools, double free, free of a never-issued slot, live count floor at zero.
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_op(ACT_ALLOC, 13'h1FFF);          // handle field ignored; opens pool 0
    send_op(ACT_ALLOC, 13'h0000);
    send_op(ACT_FREE,  13'd1023);
    send_op(ACT_ALLOC, 13'h0AAA);          // reuse from the free list
    send_op(ACT_ALLOC, 13'h1555);
    send_op(ACT_FREE,  13'd1024);          // pool 1 not open yet
    send_op(ACT_FREE,  13'h1FFF);          // top handle, pool 7
    send_op(ACT_FREE,  13'd1022);
    send_op(ACT_FREE,  13'd1022);          // double free
    send_op(ACT_FREE,  13'd1021);
    send_op(ACT_FREE,  13'd1023);          // live count already at zero
    send_op(ACT_FREE,  13'd0);             // slot never issued, still pushed
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);             // list empty again, back to unissued
    send_op(ACT_FREE,  13'd4096);          // middle pool, unopened
    send_op(ACT_FREE,  13'd1019);
    send_op(ACT_ALLOC, 13'd0);
    send_op(ACT_ALLOC, 13'd0);
  endtask

  // Receiver held off for a long stretch while requests keep coming, so the
  // output register fills and in_tready has to drop.
  task automatic test_output_hold_off();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    fork
      hold_receiver(HOLD_CYCLES);
    join_none
    repeat (20) begin
      send_op(ACT_ALLOC, 13'($urandom));
      send_op(ACT_FREE, last_resp.granted);
    end
  endtask

  // Mostly well-formed traffic (free what was handed out) with some noise frees,
  // run through the idling patterns twice.
  task automatic test_random_traffic();
    int tx_pattern[4];
    int rx_pattern[4];
    int pick;
    int idx;
    logic [HANDLE_W-1:0] hdl;
    tx_pattern = '{0, 59, 0, 16};
    rx_pattern = '{0, 0, 59, 16};
    for (int phase = 0; phase < 8; phase++) begin
      tx_idle_pct  = tx_pattern[phase % 4];
      rx_stall_pct = rx_pattern[phase % 4];
      repeat (RANDOM_ITEMS / 8) begin
        pick = $urandom_range(99);
        hdl  = 13'($urandom);
        if (pick < 52 || held_handles.size() == 0) begin
          send_op(ACT_ALLOC, hdl);
          if (last_resp.status == STATUS_OK) held_handles.push_back(last_resp.granted);
        end else if (pick < 88) begin
          idx = $urandom_range(held_handles.size() - 1);
          hdl = held_handles[idx];
          held_handles.delete(idx);
          send_op(ACT_FREE, hdl);
        end else if (pick < 94) begin
          send_op(ACT_FREE, hdl);                           // anywhere, mostly unopened
        end else begin
          send_op(ACT_FREE, HANDLE_W'(hdl % SLOTS_PER_POOL)); // stray free into pool 0
        end
      end
    end
    held_handles.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    reset_shadow();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_hold_off();
    test_random_traffic();

    in_tvalid    <= 1'b0;
    rx_stall_pct = 0;
    for (int c = 0; c < DRAIN_LIMIT && awaited_responses.size() != 0; c++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      $error("%0d predicted results never arrived", awaited_responses.size());
      fail_count++;
    end

    $display("%0d result transactions checked: %0d grants, %0d refused for no space,",
             n_checked, n_granted, n_no_space);
    $display("%0d frees outside open pools; %0d pools opened, live count peaked at %0d",
             n_unowned, pools_opened, peak_live);
    if (fail_count == 0) begin
      $display("** pooled_handle_allocator_unit: PASSED **");
    end else begin
      $display("** pooled_handle_allocator_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT);
    $display("** pooled_handle_allocator_unit: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/hpa_pkg.sv
rtl/core/hpa_link_ram.sv
rtl/core/hpa_pool_table.sv
rtl/core/pooled_handle_allocator_unit.sv
test/tb_pooled_handle_allocator_unit.sv
